@@ src/scc_pkg.sv @@
`timescale 1ns / 1ps
package scc_pkg;

  // fixed field widths
  localparam int IDX_W   = 12;
  localparam int POS_W   = 32;
  localparam int RAD_W   = 31;
  localparam int MASK_W  = 64;
  localparam int GM_W    = 32;
  localparam int RC_W    = 16;
  localparam int OP_W    = 2;
  localparam int SQ_W    = 64;
  localparam int ACC_W   = SQ_W + 2;

  localparam int MAX_ATOMS_DEF   = 4096;
  localparam int COUNT_WIDTH_DEF = 16;

  // input word layout, lowest bit first
  localparam int IN_IDX_I_LO = 0;
  localparam int IN_IDX_J_LO = IN_IDX_I_LO + IDX_W;
  localparam int IN_PIX_LO   = IN_IDX_J_LO + IDX_W;
  localparam int IN_PIY_LO   = IN_PIX_LO + POS_W;
  localparam int IN_PIZ_LO   = IN_PIY_LO + POS_W;
  localparam int IN_PJX_LO   = IN_PIZ_LO + POS_W;
  localparam int IN_PJY_LO   = IN_PJX_LO + POS_W;
  localparam int IN_PJZ_LO   = IN_PJY_LO + POS_W;
  localparam int IN_RI_LO    = IN_PJZ_LO + POS_W;
  localparam int IN_RJ_LO    = IN_RI_LO + RAD_W;
  localparam int IN_MASK_LO  = IN_RJ_LO + RAD_W;
  localparam int IN_USED_W   = IN_MASK_LO + MASK_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // output word layout
  localparam int OUT_RC_LO   = 0;
  localparam int OUT_HIT_BIT = OUT_RC_LO + RC_W;
  localparam int OUT_TI_BIT  = OUT_HIT_BIT + 1;
  localparam int OUT_TJ_BIT  = OUT_TI_BIT + 1;
  localparam int OUT_USED_W  = OUT_TJ_BIT + 1;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_GROUP_MASK   = 1'b0;
  localparam logic REG_PARTNER_MASK = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PAIR  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } scc_op_t;

  typedef enum logic [1:0] {
    SQ_X = 2'd0,
    SQ_Y = 2'd1,
    SQ_Z = 2'd2,
    SQ_R = 2'd3
  } scc_sq_t;

  typedef enum logic [1:0] {
    WR_INIT   = 2'd0,
    WR_CLEAR  = 2'd1,
    WR_BUMP_I = 2'd2,
    WR_BUMP_J = 2'd3
  } scc_wr_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_R,
    S_DRAIN_A,
    S_DRAIN_B,
    S_CMP,
    S_RD_I,
    S_WR_I,
    S_RD_J,
    S_WR_J,
    S_RESP
  } scc_state_t;

  typedef struct packed {
    logic [GM_W-1:0] group_mask;
    logic [GM_W-1:0] partner_mask;
  } scc_cfg_t;

  typedef struct packed {
    logic    load;      // latch the accepted word
    logic    sq_en;     // push one operand into the squarer
    scc_sq_t sq_sel;
    logic    rd_en;
    logic    rd_j;      // read address is index_j
    logic    wr_en;
    scc_wr_t wr_kind;
    logic    out_load;  // capture result payload
  } scc_cmd_t;

  typedef struct packed {
    scc_op_t op;
    logic    i_ok;      // index_i inside the store
    logic    eligible;  // some tally allowed by the masks
    logic    bump_i;
    logic    bump_j;
    logic    init_last;
  } scc_stat_t;

endpackage

@@ src/scc_regs.sv @@
`timescale 1ns / 1ps
module scc_regs
  import scc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output scc_cfg_t          cfg
);

  scc_cfg_t cfg_r, cfg_nxt;
  logic     wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // word aligned decode: bit 2 picks the register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (cfg_paddr[2])
        REG_GROUP_MASK:   cfg_nxt.group_mask   = cfg_pwdata;
        REG_PARTNER_MASK: cfg_nxt.partner_mask = cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_mask   <= GM_W'(1);
      cfg_r.partner_mask <= GM_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_GROUP_MASK:   cfg_prdata = cfg_r.group_mask;
      REG_PARTNER_MASK: cfg_prdata = cfg_r.partner_mask;
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ src/scc_ctrl.sv @@
`timescale 1ns / 1ps
module scc_ctrl
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  scc_stat_t stat,
  output scc_cmd_t  cmd
);

  scc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:    if (stat.init_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_tvalid) state_nxt = S_DECODE;
      S_DECODE: begin
        if (stat.op == OP_PAIR && stat.eligible) state_nxt = S_SQ_X;
        else state_nxt = S_RESP;
      end
      S_SQ_X:    state_nxt = S_SQ_Y;
      S_SQ_Y:    state_nxt = S_SQ_Z;
      S_SQ_Z:    state_nxt = S_SQ_R;
      S_SQ_R:    state_nxt = S_DRAIN_A;
      S_DRAIN_A: state_nxt = S_DRAIN_B;
      S_DRAIN_B: state_nxt = S_CMP;
      S_CMP: begin
        priority if (stat.bump_i) state_nxt = S_RD_I;
        else if (stat.bump_j)     state_nxt = S_RD_J;
        else                      state_nxt = S_RESP;
      end
      S_RD_I:    state_nxt = S_WR_I;
      S_WR_I:    state_nxt = stat.bump_j ? S_RD_J : S_RESP;
      S_RD_J:    state_nxt = S_WR_J;
      S_WR_J:    state_nxt = S_RESP;
      S_RESP:    if (slot_free) state_nxt = S_IDLE;
      default:   state_nxt = S_INIT;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.load = in_tvalid && in_tready;
    unique case (state_r)
      S_INIT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_INIT;
      end
      S_DECODE: begin
        cmd.wr_en   = (stat.op == OP_CLEAR) && stat.i_ok;
        cmd.wr_kind = WR_CLEAR;
        cmd.rd_en   = (stat.op == OP_READ);
      end
      S_SQ_X: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_X;
      end
      S_SQ_Y: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_Y;
      end
      S_SQ_Z: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_Z;
      end
      S_SQ_R: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = SQ_R;
      end
      S_RD_I: cmd.rd_en = 1'b1;
      S_WR_I: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_BUMP_I;
      end
      S_RD_J: begin
        cmd.rd_en = 1'b1;
        cmd.rd_j  = 1'b1;
      end
      S_WR_J: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_kind = WR_BUMP_J;
      end
      S_RESP: cmd.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted word not followed by decode");

  a_rd_needs_bump: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD_I) |-> stat.bump_i) and ((state_r == S_RD_J) |-> stat.bump_j))
    else $error("count update without an eligible tally");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !cmd.out_load)
    else $error("result loaded over a waiting word");

endmodule

@@ src/scc_dp.sv @@
`timescale 1ns / 1ps
module scc_dp
  import scc_pkg::*;
#(
  parameter int MAX_ATOMS   = MAX_ATOMS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  scc_cfg_t              cfg,
  input  scc_cmd_t              cmd,
  output scc_stat_t             stat
);

  localparam int AW = $clog2(MAX_ATOMS);
  localparam int CW = COUNT_WIDTH;
  localparam int EW = IDX_W + AW;

  // latched item
  scc_op_t            op_r;
  logic [IDX_W-1:0]   idx_i_r, idx_j_r;
  logic [POS_W-1:0]   pix_r, piy_r, piz_r, pjx_r, pjy_r, pjz_r;
  logic [RAD_W-1:0]   ri_r, rj_r;
  logic [MASK_W-1:0]  masks_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= scc_op_t'(in_tuser);
      idx_i_r <= in_tdata[IN_IDX_I_LO +: IDX_W];
      idx_j_r <= in_tdata[IN_IDX_J_LO +: IDX_W];
      pix_r   <= in_tdata[IN_PIX_LO +: POS_W];
      piy_r   <= in_tdata[IN_PIY_LO +: POS_W];
      piz_r   <= in_tdata[IN_PIZ_LO +: POS_W];
      pjx_r   <= in_tdata[IN_PJX_LO +: POS_W];
      pjy_r   <= in_tdata[IN_PJY_LO +: POS_W];
      pjz_r   <= in_tdata[IN_PJZ_LO +: POS_W];
      ri_r    <= in_tdata[IN_RI_LO +: RAD_W];
      rj_r    <= in_tdata[IN_RJ_LO +: RAD_W];
      masks_r <= in_tdata[IN_MASK_LO +: MASK_W];
    end
  end

  // index range and address
  logic [EW-1:0] ext_i, ext_j;
  logic [AW-1:0] addr_i, addr_j;
  logic          i_ok, j_ok;

  assign ext_i  = {{AW{1'b0}}, idx_i_r};
  assign ext_j  = {{AW{1'b0}}, idx_j_r};
  assign addr_i = ext_i[AW-1:0];
  assign addr_j = ext_j[AW-1:0];
  assign i_ok   = ext_i < EW'(MAX_ATOMS);
  assign j_ok   = ext_j < EW'(MAX_ATOMS);

  // group eligibility
  logic [GM_W-1:0] mi, mj;
  logic            up_i, up_j;

  assign mi   = masks_r[MASK_W-1 -: GM_W];
  assign mj   = masks_r[GM_W-1:0];
  assign up_i = (|(mi & cfg.group_mask)) && (|(mj & cfg.partner_mask));
  assign up_j = (|(mj & cfg.group_mask)) && (|(mi & cfg.partner_mask));

  // squarer: |delta| stage, product stage, accumulate stage
  logic [POS_W-1:0] op_a, op_b;
  logic [POS_W:0]   d_ab, d_ba;
  logic [POS_W-1:0] rsum;
  logic [POS_W-1:0] mag_nxt, mag_r;
  logic             mag_v_r, mag_rs_r;
  logic [SQ_W-1:0]  prod_r;
  logic             prod_v_r, prod_rs_r;
  logic [ACC_W-1:0] acc_r;
  logic [SQ_W-1:0]  rsq_r;
  logic             le;

  always_comb begin
    unique case (cmd.sq_sel)
      SQ_X:    begin op_a = pix_r; op_b = pjx_r; end
      SQ_Y:    begin op_a = piy_r; op_b = pjy_r; end
      SQ_Z:    begin op_a = piz_r; op_b = pjz_r; end
      default: begin op_a = pix_r; op_b = pjx_r; end
    endcase
  end

  assign d_ab = {op_a[POS_W-1], op_a} - {op_b[POS_W-1], op_b};
  assign d_ba = {op_b[POS_W-1], op_b} - {op_a[POS_W-1], op_a};
  assign rsum = {1'b0, ri_r} + {1'b0, rj_r};
  // magnitude never exceeds 2^32-1, so the sign bit drops
  assign mag_nxt = (cmd.sq_sel == SQ_R) ? rsum
                 : (d_ab[POS_W] ? d_ba[POS_W-1:0] : d_ab[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      mag_v_r  <= cmd.sq_en;
      prod_v_r <= mag_v_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    mag_rs_r  <= (cmd.sq_sel == SQ_R);
    prod_r    <= mag_r * mag_r;
    prod_rs_r <= mag_rs_r;
    if (cmd.load) begin
      acc_r <= '0;
      rsq_r <= '0;
    end else if (prod_v_r) begin
      if (prod_rs_r) rsq_r <= prod_r;
      else           acc_r <= acc_r + {2'b00, prod_r};
    end
  end

  assign le = acc_r <= {2'b00, rsq_r};

  logic hit, bump_i, bump_j;
  assign hit    = (op_r == OP_PAIR) && (up_i || up_j) && le;
  assign bump_i = hit && up_i && i_ok;
  assign bump_j = hit && up_j && j_ok;

  // count store
  logic [CW-1:0] mem [MAX_ATOMS];
  logic [CW-1:0] rd_data_r;
  logic [CW-1:0] wr_data, bumped;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] init_addr_r;
  logic          init_last;

  assign init_last = (init_addr_r == AW'(MAX_ATOMS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_addr_r <= '0;
    end else if (cmd.wr_en && cmd.wr_kind == WR_INIT && !init_last) begin
      init_addr_r <= init_addr_r + AW'(1);
    end
  end

  assign bumped  = (&rd_data_r) ? rd_data_r : rd_data_r + CW'(1);
  assign rd_addr = cmd.rd_j ? addr_j : addr_i;

  always_comb begin
    unique case (cmd.wr_kind)
      WR_INIT:   begin wr_addr = init_addr_r; wr_data = '0;     end
      WR_CLEAR:  begin wr_addr = addr_i;      wr_data = '0;     end
      WR_BUMP_I: begin wr_addr = addr_i;      wr_data = bumped; end
      WR_BUMP_J: begin wr_addr = addr_j;      wr_data = bumped; end
      default:   begin wr_addr = addr_i;      wr_data = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  // result payload
  logic [CW+RC_W-1:0] rd_ext;
  logic [RC_W-1:0]    read_count_r;
  logic               in_contact_r, tallied_i_r, tallied_j_r;

  assign rd_ext = {{RC_W{1'b0}}, rd_data_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_count_r <= (op_r == OP_READ && i_ok) ? rd_ext[RC_W-1:0] : '0;
      in_contact_r <= hit;
      tallied_i_r  <= bump_i;
      tallied_j_r  <= bump_j;
    end
  end

  assign out_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                      tallied_j_r, tallied_i_r, in_contact_r, read_count_r};

  assign stat.op        = op_r;
  assign stat.i_ok      = i_ok;
  assign stat.eligible  = up_i || up_j;
  assign stat.bump_i    = bump_i;
  assign stat.bump_j    = bump_j;
  assign stat.init_last = init_last;

  a_sat_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && (cmd.wr_kind == WR_BUMP_I || cmd.wr_kind == WR_BUMP_J))
      |-> (wr_data != '0))
    else $error("count update wrapped to zero");

  a_bump_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.wr_kind == WR_BUMP_I) |-> $past(cmd.rd_en && !cmd.rd_j))
    else $error("count update without a preceding read of the entry");

endmodule

@@ src/sphere_contact_counter_core.sv @@
`timescale 1ns / 1ps
// Sphere contact counter. Keeps one saturating contact count per atom
// (MAX_ATOMS entries of COUNT_WIDTH bits) and takes three kinds of word on
// the input stream, chosen by in_tuser: clear an entry, tally a pair, or read
// an entry. A pair is in contact when the exact squared distance of the two
// Q16.16 positions is at most the squared radius sum; atom i is tallied when
// it is in group_mask and j in partner_group_mask, atom j in the mirror case.
// Every input word yields exactly one output word. After reset the block
// clears every entry of the count store in one pass and holds in_tready
// low until it is done; register writes are taken during that pass. A word
// is taken only when idle and finished before the next; clear, read, unused
// op and a pair that no mask allows go from decode straight to the response
// step. An eligible pair feeds the single shared 32x32 squarer one operand
// per cycle (three deltas and the radius sum) through a two-stage pipe,
// drains it and compares, then does the single-port read-modify-write of
// each count it updates. A result that is not taken holds the block in its
// response step until out_tready frees the output register.
module sphere_contact_counter_core
  import scc_pkg::*;
#(
  parameter int MAX_ATOMS   = MAX_ATOMS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // in_tuser: op
  input  logic [OP_W-1:0]       in_tuser,
  // in_tdata: index_i, index_j, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y,
  //           pos_j_z, radius_i, radius_j, masks, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_tdata: read_count, in_contact, tallied_i, tallied_j, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  scc_cfg_t  cfg;
  scc_cmd_t  cmd;
  scc_stat_t stat;

  // group_mask at 0x0, partner_group_mask at 0x4
  scc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer: clearing pass, operand order, count updates, output handshake
  scc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // item latch, squarer and accumulator, count store, result register
  scc_dp #(
    .MAX_ATOMS   (MAX_ATOMS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ test/sphere_contact_counter_core_tb.sv @@
`timescale 1ns / 1ps
module sphere_contact_counter_core_tb;
  import scc_pkg::*;

  // Generous ceiling. The slowest correct run is the reset clearing pass and
  // every word on the longest pair path plus the longest gap and the longest stall.
  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int RANDOM_PER_PHASE = 315;
  localparam int NUM_PHASES       = 6;
  localparam int SAT_PAIRS        = 32;     // two bumps per pair
  localparam logic [IDX_W-1:0] SAT_ATOM = 12'd7;
  localparam int SETTLE_CYCLES    = 20;

  // One input word: op in tuser, the rest in tdata. The body is declared
  // highest field first, so the packed layout matches tdata bit for bit.
  typedef struct packed {
    logic [MASK_W-1:0] masks;
    logic [RAD_W-1:0]  rad_j;
    logic [RAD_W-1:0]  rad_i;
    logic [POS_W-1:0]  pjz;
    logic [POS_W-1:0]  pjy;
    logic [POS_W-1:0]  pjx;
    logic [POS_W-1:0]  piz;
    logic [POS_W-1:0]  piy;
    logic [POS_W-1:0]  pix;
    logic [IDX_W-1:0]  idx_j;
    logic [IDX_W-1:0]  idx_i;
  } contact_body_t;

  typedef struct packed {
    scc_op_t       op;
    contact_body_t body;
  } contact_word_t;

  // result word, same layout as out_tdata without the pad
  typedef struct packed {
    logic            tallied_j;
    logic            tallied_i;
    logic            in_contact;
    logic [RC_W-1:0] read_count;
  } contact_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OP_W-1:0]       in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  sphere_contact_counter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the block: count store and the two group registers
  // ---------------------------------------------------------------------
  logic [15:0]     atom_count [MAX_ATOMS_DEF];
  logic [GM_W-1:0] grp_mask = 32'h1;
  logic [GM_W-1:0] partner_mask = 32'h1;

  contact_word_t count_cmds_q[$];     // words waiting for the driver
  contact_res_t  contact_results_q[$]; // predicted results, oldest first
  contact_word_t cur_word;             // word now on the input bus

  logic in_took = 1'b0;   // word on the bus was taken at the last edge
  int   send_gap = 0;
  int   stall_left = 0;
  bit   sender_gaps = 1'b1;
  bit   receiver_stalls = 1'b1;

  int words_issued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int pairs_seen = 0;
  int contacts_seen = 0;
  int reads_seen = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  // squared distance along one axis; delta is 33 bits, square fits 64
  function automatic logic [63:0] axis_sq(logic [31:0] a, logic [31:0] b);
    logic [32:0] d;
    logic [63:0] m;
    d = {a[31], a} - {b[31], b};
    if (d[32]) d = -d;
    m = {31'b0, d};
    return m * m;
  endfunction

  // saturating increment; every 12-bit index lies inside the store
  function automatic logic bump_count(logic [IDX_W-1:0] idx);
    if (atom_count[idx] != 16'hFFFF) atom_count[idx] = atom_count[idx] + 16'd1;
    return 1'b1;
  endfunction

  function automatic contact_res_t predict_contact(contact_word_t w);
    contact_res_t    r;
    logic [GM_W-1:0] mi;
    logic [GM_W-1:0] mj;
    logic            up_i;
    logic            up_j;
    logic [65:0]     dsq;
    logic [31:0]     rsum;
    logic [63:0]     rsq;
    r = '0;
    case (w.op)
      OP_CLEAR: atom_count[w.body.idx_i] = '0;
      OP_READ:  r.read_count = atom_count[w.body.idx_i];
      OP_PAIR: begin
        mi = w.body.masks[63:32];
        mj = w.body.masks[31:0];
        up_i = |(mi & grp_mask) && |(mj & partner_mask);
        up_j = |(mj & grp_mask) && |(mi & partner_mask);
        if (up_i || up_j) begin
          // exact compare: 66-bit sum against the 64-bit squared radius sum
          dsq = 66'(axis_sq(w.body.pix, w.body.pjx)) + 66'(axis_sq(w.body.piy, w.body.pjy))
              + 66'(axis_sq(w.body.piz, w.body.pjz));
          rsum = {1'b0, w.body.rad_i} + {1'b0, w.body.rad_j};
          rsq = {32'b0, rsum} * {32'b0, rsum};
          if (dsq <= {2'b0, rsq}) begin
            r.in_contact = 1'b1;
            if (up_i) r.tallied_i = bump_count(w.body.idx_i);
            if (up_j) r.tallied_j = bump_count(w.body.idx_j);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // a small pool of atoms so counts build up, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_atom();
    if ($urandom_range(0, 99) < 80) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom);
  endfunction

  function automatic logic [GM_W-1:0] group_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom;
    if (r < 80) return 32'h1 << $urandom_range(0, 3);
    if (r < 90) return 32'h0;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] near_coord(logic [31:0] base, int lim);
    return base + 32'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  function automatic contact_body_t noise_body();
    logic [351:0]  raw;
    contact_body_t b;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    b = raw[IN_USED_W-1:0];
    return b;
  endfunction

  function automatic contact_word_t index_word(scc_op_t op, logic [IDX_W-1:0] idx);
    contact_word_t w;
    w.op = op;
    w.body = noise_body();
    w.body.idx_i = idx;
    return w;
  endfunction

  // pair with both atoms at the origin; callers move them as needed
  function automatic contact_word_t pair_word(logic [IDX_W-1:0] ii, logic [IDX_W-1:0] jj,
                                              logic [RAD_W-1:0] ri, logic [RAD_W-1:0] rj,
                                              logic [MASK_W-1:0] masks);
    contact_word_t w;
    w = '0;
    w.op = OP_PAIR;
    w.body.idx_i = ii;
    w.body.idx_j = jj;
    w.body.rad_i = ri;
    w.body.rad_j = rj;
    w.body.masks = masks;
    return w;
  endfunction

  function automatic contact_word_t random_word();
    contact_word_t w;
    int            r;
    int            lim;
    logic [31:0]   b;
    r = $urandom_range(0, 99);
    if (r < 8) return index_word(OP_CLEAR, pick_atom());
    if (r < 22) return index_word(OP_READ, pick_atom());
    if (r < 26) begin
      w.op = OP_NONE;
      w.body = noise_body();
      return w;
    end
    w.op = OP_PAIR;
    w.body = noise_body();
    w.body.idx_i = pick_atom();
    w.body.idx_j = pick_atom();
    w.body.masks = {group_bits(), group_bits()};
    if ($urandom_range(0, 99) < 70) begin
      // centers within one radius sum per axis: roughly half touch
      w.body.rad_i = RAD_W'($urandom_range(0, 1 << 20));
      w.body.rad_j = RAD_W'($urandom_range(0, 1 << 20));
      lim = int'(w.body.rad_i) + int'(w.body.rad_j);
      b = $urandom;
      w.body.pix = {{4{b[27]}}, b[27:0]};
      b = $urandom;
      w.body.piy = {{4{b[27]}}, b[27:0]};
      b = $urandom;
      w.body.piz = {{4{b[27]}}, b[27:0]};
      if ($urandom_range(0, 99) < 5) begin
        // exactly touching along x
        w.body.pjx = w.body.pix + 32'(lim);
        w.body.pjy = w.body.piy;
        w.body.pjz = w.body.piz;
      end else begin
        w.body.pjx = near_coord(w.body.pix, lim);
        w.body.pjy = near_coord(w.body.piy, lim);
        w.body.pjz = near_coord(w.body.piz, lim);
      end
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Register port and phase control
  // ---------------------------------------------------------------------
  task automatic write_reg(logic sel, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_GROUP_MASK) grp_mask = val;
    else partner_mask = val;
    reg_writes++;
  endtask

  // wait until every queued word is issued and has its result back
  task automatic wait_drained();
    do @(negedge clk); while (count_cmds_q.size() != 0 || words_issued != results_seen);
  endtask

  task automatic set_masks(logic [GM_W-1:0] gm, logic [GM_W-1:0] pm);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_GROUP_MASK, gm);
    write_reg(REG_PARTNER_MASK, pm);
  endtask

  // ---------------------------------------------------------------------
  // Input driver: presents queued words at the falling edge, holds a word
  // until it is taken, then idles for a random gap.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // word still waiting for in_tready
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (count_cmds_q.size() != 0) begin
      cur_word = count_cmds_q.pop_front();
      in_tuser  <= cur_word.op;
      in_tdata  <= IN_DATA_W'(cur_word.body);
      in_tvalid <= 1'b1;
      words_issued++;
      send_gap = sender_gaps ? idle_len() : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (receiver_stalls && $urandom_range(0, 99) < 25) stall_left = idle_len() + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and predictor at the rising edge: check the result word taken
  // here first, then predict for the input word taken here.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    contact_res_t got;
    contact_res_t want;
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_USED_W-1:0];
        results_seen++;
        if (got.in_contact) contacts_seen++;
        if (contact_results_q.size() == 0) begin
          $error("result word with no prediction waiting: %h", got);
          mismatches++;
        end else begin
          want = contact_results_q.pop_front();
          if (got.read_count !== want.read_count) begin
            $error("read_count: expected %0d, got %0d", want.read_count, got.read_count);
            mismatches++;
          end
          if (got.in_contact !== want.in_contact) begin
            $error("in_contact: expected %0b, got %0b", want.in_contact, got.in_contact);
            mismatches++;
          end
          if (got.tallied_i !== want.tallied_i) begin
            $error("tallied_i: expected %0b, got %0b", want.tallied_i, got.tallied_i);
            mismatches++;
          end
          if (got.tallied_j !== want.tallied_j) begin
            $error("tallied_j: expected %0b, got %0b", want.tallied_j, got.tallied_j);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (cur_word.op == OP_PAIR) pairs_seen++;
        if (cur_word.op == OP_READ) reads_seen++;
        contact_results_q.push_back(predict_contact(cur_word));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("sphere_contact_counter_core_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    contact_word_t   w;
    logic [GM_W-1:0] gm_set [NUM_PHASES];
    logic [GM_W-1:0] pm_set [NUM_PHASES];

    for (int k = 0; k < MAX_ATOMS_DEF; k++) atom_count[k] = '0;
    gm_set = '{32'h2, 32'hFFFF_FFFF, 32'h0, $urandom, 32'h1, 32'hF};
    pm_set = '{32'h4, 32'hFFFF_FFFF, 32'h0, $urandom, 32'hFFFF_FFFF, 32'h3};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words under the reset masks (1, 1); the driver waits out
    // the clearing pass on in_tready
    count_cmds_q.push_back(index_word(OP_READ, 12'd0));
    count_cmds_q.push_back(index_word(OP_READ, 12'hFFF));
    // coincident atoms with zero radii: distance 0 equals radius sum 0
    count_cmds_q.push_back(pair_word(12'd0, 12'd1, '0, '0, {32'h1, 32'h1}));
    // touching exactly along x, then one LSB apart
    w = pair_word(12'd2, 12'd3, 31'h1_0000, 31'h1_0000, {32'h1, 32'h1});
    w.body.pjx = 32'h0002_0000;
    count_cmds_q.push_back(w);
    w.body.pjx = 32'h0002_0001;
    count_cmds_q.push_back(w);
    // two extreme axes with maximal radii: low word of the sum wraps below
    // the squared radius sum, only the carry keeps them apart
    w = pair_word(12'd4, 12'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, {32'h1, 32'h1});
    w.body.pix = 32'h8000_0000;
    w.body.pjx = 32'h7FFF_FFFF;
    w.body.piy = 32'h7FFF_FFFF;
    w.body.pjy = 32'h8000_0000;
    count_cmds_q.push_back(w);
    w.body.piz = 32'h8000_0000;
    w.body.pjz = 32'h7FFF_FFFF;
    count_cmds_q.push_back(w);
    // partner not in any group: no tally, no contact
    count_cmds_q.push_back(pair_word(12'hFFF, 12'd0, '0, '0, {32'h1, 32'h0}));
    // all-ones masks, both at the most negative corner
    w = pair_word(12'hFFF, 12'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, '1);
    w.body.pix = 32'h8000_0000;
    w.body.piy = 32'h8000_0000;
    w.body.piz = 32'h8000_0000;
    w.body.pjx = 32'h8000_0000;
    w.body.pjy = 32'h8000_0000;
    w.body.pjz = 32'h8000_0000;
    count_cmds_q.push_back(w);
    // same atom on both sides counts twice
    count_cmds_q.push_back(pair_word(12'd6, 12'd6, 31'h10, 31'h10, {32'h1, 32'h1}));
    count_cmds_q.push_back(index_word(OP_READ, 12'd6));
    count_cmds_q.push_back(index_word(OP_CLEAR, 12'd6));
    count_cmds_q.push_back(index_word(OP_READ, 12'd6));
    w.op = OP_NONE;
    w.body = noise_body();
    count_cmds_q.push_back(w);
    count_cmds_q.push_back(index_word(OP_CLEAR, 12'hFFF));
    count_cmds_q.push_back(index_word(OP_READ, 12'hFFF));
    count_cmds_q.push_back(index_word(OP_READ, 12'd1));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_masks(gm_set[p], pm_set[p]);
      // one phase runs with no idling on either side
      sender_gaps = (p != 3);
      receiver_stalls = (p != 3);
      if (p == 0) begin
        // masks 2 / 4: one-sided tallies in each direction, then both
        count_cmds_q.push_back(pair_word(12'd8, 12'd9, '0, '0, {32'h2, 32'h4}));
        count_cmds_q.push_back(pair_word(12'd8, 12'd9, '0, '0, {32'h4, 32'h2}));
        count_cmds_q.push_back(pair_word(12'd8, 12'd9, '0, '0, {32'h6, 32'h6}));
        count_cmds_q.push_back(index_word(OP_READ, 12'd8));
        count_cmds_q.push_back(index_word(OP_READ, 12'd9));
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) count_cmds_q.push_back(random_word());
    end

    // same atom on both sides, back to back, then read the running count
    set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    count_cmds_q.push_back(index_word(OP_CLEAR, SAT_ATOM));
    for (int n = 0; n < SAT_PAIRS; n++)
      count_cmds_q.push_back(pair_word(SAT_ATOM, SAT_ATOM, '0, '0, '1));
    count_cmds_q.push_back(index_word(OP_READ, SAT_ATOM));
    count_cmds_q.push_back(index_word(OP_CLEAR, SAT_ATOM));
    count_cmds_q.push_back(index_word(OP_READ, SAT_ATOM));

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (contact_results_q.size() != 0) begin
      $error("%0d predicted results never arrived", contact_results_q.size());
      mismatches++;
    end

    $display("run covered %0d words: %0d pairs (%0d in contact), %0d reads, same-atom burst",
             results_seen, pairs_seen, contacts_seen, reads_seen);
    $display("%0d register writes over %0d mask settings, %0d mismatches",
             reg_writes, NUM_PHASES + 1, mismatches);
    if (mismatches == 0) begin
      $display("sphere_contact_counter_core_tb: PASS");
    end else begin
      $display("sphere_contact_counter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
